// File: src/pci_pkg.sv
// Package for the photon cut identification pipeline.
// Holds cut constants, threshold tables and effective-area tables.
// No dependencies.
package pci_pkg;

    // Working point codes
    localparam logic [1:0] WP_LOOSE  = 2'd0;
    localparam logic [1:0] WP_MEDIUM = 2'd1;
    localparam logic [1:0] WP_TIGHT  = 2'd2;

    // Detector region codes
    localparam logic REG_BARREL = 1'b0;
    localparam logic REG_ENDCAP = 1'b1;

    typedef logic [16:0] t_eta_mag;
    typedef logic [2:0]  t_bin;

    // |eta| boundaries, units of 1/4096
    localparam t_eta_mag ETA_FID_MAX = 17'd10240;
    localparam t_eta_mag CRACK_LO    = 17'd5916;
    localparam t_eta_mag CRACK_HI    = 17'd6414;
    localparam t_eta_mag BARREL_MAX  = 17'd5915;

    // Fixed cuts
    localparam logic [15:0] ET_MIN  = 16'd240;
    localparam logic [15:0] HOE_THR = 16'd205;

    // Scale factors of the exact threshold arithmetic
    localparam int unsigned ISO_SCALE    = 10000;
    localparam int unsigned NEU_C0_SCALE = 2560000;
    localparam int unsigned NEU_C1_SCALE = 1600;
    localparam int unsigned NEU_RND      = 8000000;
    localparam int unsigned PHO_C0_SCALE = 1600;
    localparam int unsigned PHO_RND      = 5000;

    // Neutral threshold divide by 16e6 = 2^9 * 31250
    localparam int unsigned NEU_PRE_SH = 9;
    localparam int unsigned NEU_DIV    = 31250;
    localparam int unsigned NEU_RCP    = 17179;  // floor(2^29 / 31250)
    localparam int unsigned NEU_RCP_SH = 29;
    // Photon threshold divide by 10000
    localparam int unsigned PHO_DIV    = 10000;
    localparam int unsigned PHO_RCP    = 419;    // floor(2^22 / 10000)
    localparam int unsigned PHO_RCP_SH = 22;

    // Effective-area bin from |eta|
    function automatic t_bin area_bin(input t_eta_mag a);
        t_bin b;
        b = '0;
        if (a >= 17'd4096) b = b + 3'd1;
        if (a >= 17'd6058) b = b + 3'd1;
        if (a >= 17'd8192) b = b + 3'd1;
        if (a >= 17'd9012) b = b + 3'd1;
        if (a >= 17'd9421) b = b + 3'd1;
        if (a >= 17'd9831) b = b + 3'd1;
        return b;
    endfunction

    // Neutral effective area, units of 1/10000
    function automatic logic [9:0] area_neu(input t_bin b);
        case (b)
            3'd0:    return 10'd599;
            3'd1:    return 10'd819;
            3'd2:    return 10'd696;
            3'd3:    return 10'd360;
            3'd4:    return 10'd360;
            3'd5:    return 10'd462;
            default: return 10'd656;
        endcase
    endfunction

    // Photon effective area, units of 1/10000
    function automatic logic [11:0] area_pho(input t_bin b);
        case (b)
            3'd0:    return 12'd1271;
            3'd1:    return 12'd1101;
            3'd2:    return 12'd756;
            3'd3:    return 12'd1175;
            3'd4:    return 12'd1498;
            3'd5:    return 12'd1857;
            default: return 12'd2183;
        endcase
    endfunction

    // Sigma-ieta-ieta cut; undefined working point acts as tight
    function automatic logic [15:0] sie_thr(input logic rg, input logic [1:0] wp);
        case (wp)
            WP_LOOSE:  return (rg == REG_BARREL) ? 16'd668 : 16'd1796;
            WP_MEDIUM: return (rg == REG_BARREL) ? 16'd668 : 16'd1756;
            default:   return (rg == REG_BARREL) ? 16'd655 : 16'd1756;
        endcase
    endfunction

    // Charged isolation cut, 1/16 GeV
    function automatic logic [5:0] ch_thr(input logic rg, input logic [1:0] wp);
        case (wp)
            WP_LOOSE:  return (rg == REG_BARREL) ? 6'd53 : 6'd32;
            WP_MEDIUM: return (rg == REG_BARREL) ? 6'd22 : 6'd18;
            default:   return (rg == REG_BARREL) ? 6'd12 : 6'd9;
        endcase
    endfunction

    // Neutral threshold constant term, 1/100 GeV
    function automatic logic [10:0] neu_c0(input logic rg, input logic [1:0] wp);
        case (wp)
            WP_LOOSE:  return (rg == REG_BARREL) ? 11'd192 : 11'd1186;
            WP_MEDIUM: return (rg == REG_BARREL) ? 11'd106 : 11'd269;
            default:   return (rg == REG_BARREL) ? 11'd97  : 11'd209;
        endcase
    endfunction

    // Neutral linear term, 1/10000 per GeV
    function automatic logic [7:0] neu_c1(input logic rg);
        return (rg == REG_BARREL) ? 8'd140 : 8'd139;
    endfunction

    // Neutral quadratic term, 1/1000000 per GeV^2
    function automatic logic [4:0] neu_c2(input logic rg);
        return (rg == REG_BARREL) ? 5'd19 : 5'd25;
    endfunction

    // Photon threshold constant term, 1/100 GeV
    function automatic logic [6:0] pho_c0(input logic rg, input logic [1:0] wp);
        case (wp)
            WP_LOOSE:  return (rg == REG_BARREL) ? 7'd81 : 7'd83;
            WP_MEDIUM: return (rg == REG_BARREL) ? 7'd28 : 7'd39;
            default:   return (rg == REG_BARREL) ? 7'd8  : 7'd16;
        endcase
    endfunction

    // Photon linear term, 1/10000 per GeV
    function automatic logic [5:0] pho_c1(input logic rg);
        return (rg == REG_BARREL) ? 6'd53 : 6'd34;
    endfunction

endpackage

// File: src/pci_rdiv.sv
// Two-stage divide by a constant: reciprocal multiply, then one
// compare-and-subtract correction. Standalone, no package use.
module pci_rdiv #(
    parameter int unsigned IN_W   = 29,
    parameter int unsigned DIV    = 31250,
    parameter int unsigned RCP    = 17179,
    parameter int unsigned RCP_SH = 29,
    parameter int unsigned Q_W    = 15
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [IN_W-1:0] i_num,
    output logic [Q_W-1:0]  o_quo
);

    localparam int unsigned RCP_W  = $clog2(RCP + 1);
    localparam int unsigned PROD_W = IN_W + RCP_W;

    logic [PROD_W-1:0] w_prod;
    logic [Q_W-1:0]    w_qe;
    logic [IN_W-1:0]   w_rem;
    logic [Q_W-1:0]    w_quo;

    logic [IN_W-1:0]   r_num;
    logic [Q_W-1:0]    r_qe;
    logic [Q_W-1:0]    r_quo;

    // Estimate is the true quotient or one below it
    assign w_prod = PROD_W'(i_num) * PROD_W'(RCP);
    assign w_qe   = Q_W'(w_prod >> RCP_SH);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= i_num;
            r_qe  <= w_qe;
        end
    end

    // Remainder stays below twice the divisor: one correction step
    assign w_rem = r_num - IN_W'(r_qe) * IN_W'(DIV);
    assign w_quo = (w_rem >= IN_W'(DIV)) ? r_qe + Q_W'(1) : r_qe;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= w_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

// File: src/photon_cut_identification.sv
// Top level of the cut-based photon identification pipeline.
// Uses pci_pkg and two pci_rdiv threshold dividers.
//
// One candidate word enters per clock, with no gaps while the output word
// is taken. The six stages are: eta magnitude and fixed cuts, the Et/rho
// products, the threshold sums and corrected isolations, two stages of
// reciprocal divide for the rounded neutral and photon thresholds, and the
// final isolation compare into the output register. When the output word
// is not taken the whole pipeline holds, so o_ready follows (!o_valid ||
// i_ready). The user writes the working point through i_wp_we / i_wp_data
// only while no word is in flight; the block itself does not enforce this.
module photon_cut_identification (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration
    input  logic        i_wp_we,
    input  logic [1:0]  i_wp_data,
    // Candidate input
    input  logic        i_valid,
    output logic        o_ready,
    input  logic signed [15:0] i_sc_eta,
    input  logic [15:0] i_trans_energy,
    input  logic [15:0] i_charged_iso,
    input  logic [15:0] i_neutral_iso,
    input  logic [15:0] i_photon_iso,
    input  logic [15:0] i_hadronic_ratio,
    input  logic [15:0] i_shower_width,
    input  logic [11:0] i_pileup_density,
    // Result output
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_pass
);

    import pci_pkg::*;

    localparam int unsigned YN_W = 29;
    localparam int unsigned XP_W = 22;
    localparam int unsigned TN_W = 15;
    localparam int unsigned TP_W = 9;

    logic w_adv;

    // Working point register
    logic [1:0] r_wp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= WP_LOOSE;
        end else if (i_wp_we) begin
            r_wp <= i_wp_data;
        end
    end

    // Whole pipeline moves unless the output word is stalled
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    // ---------------- Stage 1: eta, region, fixed cuts ----------------
    t_eta_mag w_a;
    logic     w_rg;
    logic     w_ok1;

    assign w_a  = i_sc_eta[15] ? (17'h10000 - {1'b0, i_sc_eta}) : {1'b0, i_sc_eta};
    assign w_rg = (w_a > BARREL_MAX) ? REG_ENDCAP : REG_BARREL;

    always_comb begin
        w_ok1 = 1'b1;
        if (w_a > ETA_FID_MAX)                                 w_ok1 = 1'b0;
        if (w_a >= CRACK_LO && w_a <= CRACK_HI)                w_ok1 = 1'b0;
        if (i_trans_energy <= ET_MIN)                          w_ok1 = 1'b0;
        if (i_hadronic_ratio >= HOE_THR)                       w_ok1 = 1'b0;
        if (i_shower_width >= sie_thr(w_rg, r_wp))             w_ok1 = 1'b0;
        if (i_charged_iso >= {10'd0, ch_thr(w_rg, r_wp)})      w_ok1 = 1'b0;
    end

    logic        r1_v;
    logic        r1_ok;
    logic        r1_rg;
    t_bin        r1_bin;
    logic [1:0]  r1_wp;
    logic [15:0] r1_et;
    logic [31:0] r1_et2;
    logic [15:0] r1_nei;
    logic [15:0] r1_phi;
    logic [11:0] r1_rho;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_ok  <= w_ok1;
            r1_rg  <= w_rg;
            r1_bin <= area_bin(w_a);
            r1_wp  <= r_wp;
            r1_et  <= i_trans_energy;
            r1_et2 <= 32'(i_trans_energy) * 32'(i_trans_energy);
            r1_nei <= i_neutral_iso;
            r1_phi <= i_photon_iso;
            r1_rho <= i_pileup_density;
        end
    end

    // ---------------- Stage 2: coefficient and rho products ----------------
    logic        r2_v;
    logic        r2_ok;
    logic [36:0] r2_n2;
    logic [23:0] r2_n1;
    logic [21:0] r2_p1;
    logic [21:0] r2_rn;
    logic [23:0] r2_rp;
    logic [10:0] r2_c0n;
    logic [6:0]  r2_c0p;
    logic [15:0] r2_nei;
    logic [15:0] r2_phi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_adv) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_ok  <= r1_ok;
            r2_n2  <= 37'(r1_et2) * 37'(neu_c2(r1_rg));
            r2_n1  <= 24'(r1_et) * 24'(neu_c1(r1_rg));
            r2_p1  <= 22'(r1_et) * 22'(pho_c1(r1_rg));
            r2_rn  <= 22'(r1_rho) * 22'(area_neu(r1_bin));
            r2_rp  <= 24'(r1_rho) * 24'(area_pho(r1_bin));
            r2_c0n <= neu_c0(r1_rg, r1_wp);
            r2_c0p <= pho_c0(r1_rg, r1_wp);
            r2_nei <= r1_nei;
            r2_phi <= r1_phi;
        end
    end

    // ---------------- Stage 3: threshold numerators, corrected iso ----------------
    logic [37:0]        w_numn;
    logic [XP_W-1:0]    w_xp;
    logic signed [31:0] w_ln;
    logic signed [31:0] w_lp;

    assign w_numn = 38'(r2_c0n) * 38'(NEU_C0_SCALE) + 38'(r2_n1) * 38'(NEU_C1_SCALE)
                  + 38'(r2_n2) + 38'(NEU_RND);
    assign w_xp   = XP_W'(r2_c0p) * XP_W'(PHO_C0_SCALE) + XP_W'(r2_p1) + XP_W'(PHO_RND);
    assign w_ln   = 32'(r2_nei) * 32'(ISO_SCALE) - 32'(r2_rn);
    assign w_lp   = 32'(r2_phi) * 32'(ISO_SCALE) - 32'(r2_rp);

    logic               r3_v;
    logic               r3_ok;
    logic [YN_W-1:0]    r3_yn;
    logic [XP_W-1:0]    r3_xp;
    logic signed [31:0] r3_ln;
    logic signed [31:0] r3_lp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_adv) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_ok <= r2_ok;
            r3_yn <= YN_W'(w_numn >> NEU_PRE_SH);
            r3_xp <= w_xp;
            r3_ln <= w_ln;
            r3_lp <= w_lp;
        end
    end

    // ---------------- Stages 4-5: rounded thresholds ----------------
    logic [TN_W-1:0] w_tneu;
    logic [TP_W-1:0] w_tpho;

    pci_rdiv #(
        .IN_W   (YN_W),
        .DIV    (NEU_DIV),
        .RCP    (NEU_RCP),
        .RCP_SH (NEU_RCP_SH),
        .Q_W    (TN_W)
    ) u_div_neu (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (r3_yn),
        .o_quo  (w_tneu)
    );

    pci_rdiv #(
        .IN_W   (XP_W),
        .DIV    (PHO_DIV),
        .RCP    (PHO_RCP),
        .RCP_SH (PHO_RCP_SH),
        .Q_W    (TP_W)
    ) u_div_pho (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (r3_xp),
        .o_quo  (w_tpho)
    );

    logic               r4_v;
    logic               r4_ok;
    logic signed [31:0] r4_ln;
    logic signed [31:0] r4_lp;
    logic               r5_v;
    logic               r5_ok;
    logic signed [31:0] r5_ln;
    logic signed [31:0] r5_lp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (w_adv) begin
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_ok <= r3_ok;
            r4_ln <= r3_ln;
            r4_lp <= r3_lp;
            r5_ok <= r4_ok;
            r5_ln <= r4_ln;
            r5_lp <= r4_lp;
        end
    end

    // ---------------- Stage 6: isolation compare, output register ----------------
    logic signed [31:0] w_thn;
    logic signed [31:0] w_thp;
    logic               w_pass;

    assign w_thn  = 32'(w_tneu) * 32'(ISO_SCALE);
    assign w_thp  = 32'(w_tpho) * 32'(ISO_SCALE);
    assign w_pass = r5_ok && (r5_ln < w_thn) && (r5_lp < w_thp);

    logic r6_v;
    logic r6_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_adv) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_pass <= w_pass;
        end
    end

    assign o_valid = r6_v;
    assign o_pass  = r6_pass;

endmodule

// File: src/pci_chk.sv
// Port-level checker for photon_cut_identification, with its bind.
// No package dependency.
module pci_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_pass
);

    // A stalled output word holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pass))
        else $error("output word changed while stalled");

    // Input is taken exactly when the output stage is free or draining
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("o_ready does not follow output stage");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // An accepted word reaches the output when no stall comes on its way
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready
        ##1 i_ready |=> o_valid)
        else $error("accepted word did not arrive in six cycles");

endmodule

bind photon_cut_identification pci_chk u_pci_chk (.*);
